// ===== rtl/rrqs_pkg.sv =====
// ============================================================================
// rrqs_pkg
// Shared types, constants and helpers of the round-robin quantum scheduler.
// ============================================================================
package rrqs_pkg;

    // Ready-queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 48;
    localparam int QUANT_W = 16;
    localparam int STAT_W  = 3;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 216;

    // Input kinds
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_ACCEPTED   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RAN        = 3'd1;
    localparam logic [STAT_W-1:0] STAT_IDLE       = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ZERO_BURST = 3'd4;

    // Reset value of the quantum register
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd2;

    // One ready-queue slot
    typedef struct packed {
        logic                 started;
        logic [BURST_W-1:0]   burst;
        logic [BURST_W-1:0]   rem;
        logic [TIME_W-1:0]    arrival;
        logic [ID_W-1:0]      id;
    } entry_t;

    // Circular pointer advance
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // 48-bit add that sticks at all ones
    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - TIME_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/round_robin_quantum_scheduler.sv =====
// ============================================================================
// round_robin_quantum_scheduler
// Round-robin scheduler with a time quantum; the ready queue lives in a
// synchronous RAM that is read, updated and written back per tick.
// ============================================================================
//
//  Channel   Dir   Handshake                   Contents
//  s_axis    in    s_axis_tvalid/tready        tuser: mode; tdata: proc_id, burst
//  m_axis    out   m_axis_tvalid/tready        tuser: status; tdata: result fields
//  cfg       in    cfg_wr_en (no wait)         cfg_wr_data: quantum
//
//  An arrival, a rejected arrival or a tick on an empty queue is done in ST_IDLE.
//  A tick that runs a process passes through ST_IDLE (RAM read), ST_READ
//  (compute) and ST_UPDATE (write back and total update).
//  Reset is synchronous, active low; the queue RAM is not cleared.
//  A result waits in the output register; the next transaction is taken once
//  the sequencer is idle and that register is free or being drained.
//
module round_robin_quantum_scheduler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rrqs_pkg::S_DATA_W-1:0]     s_axis_tdata,  // proc_id[15:0], burst[31:16]
    input  logic                              s_axis_tuser,  // mode[0]
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rrqs_pkg::M_DATA_W-1:0]     m_axis_tdata,  // ran_id[15:0], first_run[16],
                                                             // response_time[48:17],
                                                             // finished[49], wait_time[81:50],
                                                             // total_wait[129:82],
                                                             // total_response[177:130],
                                                             // now[209:178], zero[215:210]
    output logic [rrqs_pkg::STAT_W-1:0]       m_axis_tuser,  // status[2:0]
    // Quantum register
    input  logic                              cfg_wr_en,
    input  logic [rrqs_pkg::QUANT_W-1:0]      cfg_wr_data
);
    import rrqs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_READ   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, tail_reg;
    logic [OCC_W-1:0]      occ_reg;
    logic [QUANT_W-1:0]    slice_reg;
    logic                  requeue_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [QUANT_W-1:0]    quantum_reg;
    entry_t                held_reg;

    // Queue RAM
    entry_t                queue_mem [QUEUE_DEPTH];
    entry_t                rd_data_reg;
    logic                  fwd_reg;
    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    entry_t                mem_wdata;
    logic                  mem_re;
    logic [PTR_W-1:0]      mem_raddr;

    // Per-tick results carried from READ to UPDATE
    entry_t                calc_entry_reg;
    logic                  calc_first_reg;
    logic [TIME_W-1:0]     calc_resp_reg;
    logic                  calc_fin_reg;
    logic [TIME_W-1:0]     calc_wait_reg;

    // Output register
    logic                  out_valid_reg;
    logic [STAT_W-1:0]     out_status_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic                  out_first_reg;
    logic [TIME_W-1:0]     out_resp_reg;
    logic                  out_fin_reg;
    logic [TIME_W-1:0]     out_wait_reg;
    logic [SUM_W-1:0]      out_twait_reg;
    logic [SUM_W-1:0]      out_tresp_reg;
    logic [TIME_W-1:0]     out_now_reg;

    // Totals
    logic [SUM_W-1:0]      wait_sum, resp_sum, wait_sum_next, resp_sum_next;

    // Handshake and decoded input
    logic                  s_fire, m_fire;
    logic                  in_mode;
    logic [ID_W-1:0]       in_id;
    logic [BURST_W-1:0]    in_burst;
    logic [PTR_W-1:0]      head_eff;
    logic                  queue_full;

    // READ-stage arithmetic
    entry_t                cur;
    entry_t                cur_upd;
    logic [TIME_W-1:0]     diff;
    logic [TIME_W-1:0]     time_inc;
    logic [BURST_W-1:0]    rem_new;
    logic [QUANT_W-1:0]    slice_inc;
    logic                  preempt;

    assign in_mode  = s_axis_tuser;
    assign in_id    = s_axis_tdata[ID_W-1:0];
    assign in_burst = s_axis_tdata[ID_W+BURST_W-1:ID_W];

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = out_valid_reg && m_axis_tready;

    // Head after a pending requeue has moved the held process to the tail
    assign head_eff   = requeue_reg ? ptr_inc(head_reg) : head_reg;
    assign queue_full = (occ_reg == OCC_W'(QUEUE_DEPTH));

    // ------------------------------------------------------------------
    // RAM port control: one write, one read
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = tail_reg;
        mem_wdata = held_reg;
        mem_re    = 1'b0;
        mem_raddr = head_eff;
        if (state_reg == ST_IDLE && s_fire) begin
            if (in_mode == MODE_ARRIVE) begin
                if (in_burst != '0 && !queue_full) begin
                    mem_we            = 1'b1;
                    mem_wdata.started = 1'b0;
                    mem_wdata.burst   = in_burst;
                    mem_wdata.rem     = in_burst;
                    mem_wdata.arrival = time_reg;
                    mem_wdata.id      = in_id;
                end
            end else begin
                mem_we = requeue_reg;
                mem_re = (occ_reg != '0);
            end
        end else if (state_reg == ST_UPDATE && !calc_fin_reg) begin
            mem_we    = 1'b1;
            mem_waddr = head_reg;
            mem_wdata = calc_entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            queue_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= queue_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Tick arithmetic on the fetched head entry
    // ------------------------------------------------------------------
    always_comb begin
        cur        = fwd_reg ? held_reg : rd_data_reg;
        diff       = time_reg - cur.arrival;
        time_inc   = time_reg + 1'b1;
        rem_new    = (cur.rem == '0) ? '0 : cur.rem - 1'b1;
        slice_inc  = (slice_reg == {QUANT_W{1'b1}}) ? slice_reg : slice_reg + 1'b1;
        preempt    = (rem_new != '0) && (quantum_reg != '0) && (slice_inc >= quantum_reg);
        // Entry as written back: started, one unit less to run
        cur_upd         = cur;
        cur_upd.started = 1'b1;
        cur_upd.rem     = rem_new;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_mode == MODE_TICK && occ_reg != '0) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            slice_reg   <= '0;
            requeue_reg <= 1'b0;
            time_reg    <= '0;
            quantum_reg <= QUANTUM_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                quantum_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (in_mode == MODE_ARRIVE) begin
                            if (in_burst != '0 && !queue_full) begin
                                tail_reg <= ptr_inc(tail_reg);
                                occ_reg  <= occ_reg + 1'b1;
                            end
                        end else begin
                            // Move the held process to the tail first
                            if (requeue_reg) begin
                                head_reg    <= head_eff;
                                tail_reg    <= ptr_inc(tail_reg);
                                requeue_reg <= 1'b0;
                            end
                            if (occ_reg == '0) begin
                                time_reg <= time_inc;
                            end
                        end
                    end
                end
                ST_READ: begin
                    time_reg <= time_inc;
                    if (rem_new == '0) begin
                        head_reg  <= ptr_inc(head_reg);
                        occ_reg   <= occ_reg - 1'b1;
                        slice_reg <= '0;
                    end else if (preempt) begin
                        slice_reg   <= '0;
                        requeue_reg <= 1'b1;
                    end else begin
                        slice_reg <= slice_inc;
                    end
                end
                ST_UPDATE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers of the tick path
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            // Head just written by the requeue: take it from the hold register
            fwd_reg <= requeue_reg && (head_eff == tail_reg);
        end
        if (state_reg == ST_READ) begin
            calc_entry_reg <= cur_upd;
            calc_first_reg <= !cur.started;
            calc_resp_reg  <= cur.started ? '0 : diff;
            calc_fin_reg   <= (rem_new == '0);
            calc_wait_reg  <= (rem_new == '0) ?
                              diff + 1'b1 - {{(TIME_W-BURST_W){1'b0}}, cur.burst} : '0;
            if (preempt) begin
                held_reg <= cur_upd;
            end
        end
    end

    // ------------------------------------------------------------------
    // Totals
    // ------------------------------------------------------------------
    rrqs_totals u_totals (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wait_en       ((state_reg == ST_UPDATE) && calc_fin_reg),
        .wait_val      (calc_wait_reg),
        .resp_en       ((state_reg == ST_UPDATE) && calc_first_reg),
        .resp_val      (calc_resp_reg),
        .wait_sum      (wait_sum),
        .resp_sum      (resp_sum),
        .wait_sum_next (wait_sum_next),
        .resp_sum_next (resp_sum_next)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == ST_IDLE && s_fire &&
                      !(in_mode == MODE_TICK && occ_reg != '0)) ||
                     state_reg == ST_UPDATE) begin
            out_valid_reg <= 1'b1;
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            out_id_reg    <= '0;
            out_first_reg <= 1'b0;
            out_resp_reg  <= '0;
            out_fin_reg   <= 1'b0;
            out_wait_reg  <= '0;
            out_twait_reg <= wait_sum;
            out_tresp_reg <= resp_sum;
            out_now_reg   <= time_reg;
            if (in_mode == MODE_ARRIVE) begin
                priority if (in_burst == '0) begin
                    out_status_reg <= STAT_ZERO_BURST;
                end else if (queue_full) begin
                    out_status_reg <= STAT_FULL;
                end else begin
                    out_status_reg <= STAT_ACCEPTED;
                end
            end else begin
                out_status_reg <= STAT_IDLE;
                out_now_reg    <= time_inc;
            end
        end else if (state_reg == ST_UPDATE) begin
            out_status_reg <= STAT_RAN;
            out_id_reg     <= calc_entry_reg.id;
            out_first_reg  <= calc_first_reg;
            out_resp_reg   <= calc_resp_reg;
            out_fin_reg    <= calc_fin_reg;
            out_wait_reg   <= calc_wait_reg;
            out_twait_reg  <= wait_sum_next;
            out_tresp_reg  <= resp_sum_next;
            out_now_reg    <= time_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'd0, out_now_reg, out_tresp_reg, out_twait_reg, out_wait_reg,
                            out_fin_reg, out_resp_reg, out_first_reg, out_id_reg};

endmodule

// ===== rtl/rrqs_totals.sv =====
// ============================================================================
// rrqs_totals
// Saturating accumulators for total waiting time and total response time.
// ============================================================================
module rrqs_totals (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wait_en,
    input  logic [rrqs_pkg::TIME_W-1:0]   wait_val,
    input  logic                          resp_en,
    input  logic [rrqs_pkg::TIME_W-1:0]   resp_val,
    output logic [rrqs_pkg::SUM_W-1:0]    wait_sum,
    output logic [rrqs_pkg::SUM_W-1:0]    resp_sum,
    output logic [rrqs_pkg::SUM_W-1:0]    wait_sum_next,
    output logic [rrqs_pkg::SUM_W-1:0]    resp_sum_next
);
    import rrqs_pkg::*;

    logic [SUM_W-1:0] wait_sum_reg;
    logic [SUM_W-1:0] resp_sum_reg;

    // Next totals, held when the enable is low
    assign wait_sum_next = wait_en ? sat_add48(wait_sum_reg, wait_val) : wait_sum_reg;
    assign resp_sum_next = resp_en ? sat_add48(resp_sum_reg, resp_val) : resp_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_sum_reg <= '0;
            resp_sum_reg <= '0;
        end else begin
            wait_sum_reg <= wait_sum_next;
            resp_sum_reg <= resp_sum_next;
        end
    end

    assign wait_sum = wait_sum_reg;
    assign resp_sum = resp_sum_reg;

endmodule

// ===== rtl/rrqs_checker.sv =====
// ============================================================================
// rrqs_checker
// Port-level checks of the scheduler's result stream, bound to the top level.
// ============================================================================
module rrqs_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [rrqs_pkg::M_DATA_W-1:0]     m_axis_tdata,
    input  logic [rrqs_pkg::STAT_W-1:0]       m_axis_tuser
);
    import rrqs_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Status is always a defined code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == STAT_ACCEPTED || m_axis_tuser == STAT_RAN ||
                           m_axis_tuser == STAT_IDLE || m_axis_tuser == STAT_FULL ||
                           m_axis_tuser == STAT_ZERO_BURST))
        else $error("undefined status code");

    // Only a run reports an id, a first run or a completion
    a_no_run_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != STAT_RAN |->
            m_axis_tdata[81:0] == '0)
        else $error("run fields set on a non-run result");

    // Response and wait fields are zero unless flagged
    a_flag_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[16] || m_axis_tdata[48:17] == '0) &&
                          (m_axis_tdata[49] || m_axis_tdata[81:50] == '0))
        else $error("time field set without its flag");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the round-robin quantum scheduler. A scoreboard
// class keeps its own copy of the ready queue, clock and totals, predicts one
// result per accepted transaction and compares every result field by field.
// Directed arrivals and ticks come first, then random workload, fill, drain
// and noise sequences under several quantum settings and idling patterns.
// ============================================================================
module tb_top;

    import rrqs_pkg::*;

    // Result tdata layout, most significant field first
    typedef struct packed {
        logic [5:0]         pad;
        logic [TIME_W-1:0]  now;
        logic [SUM_W-1:0]   total_response;
        logic [SUM_W-1:0]   total_wait;
        logic [TIME_W-1:0]  wait_time;
        logic               finished;
        logic [TIME_W-1:0]  response_time;
        logic               first_run;
        logic [ID_W-1:0]    ran_id;
    } sched_fields_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        sched_fields_t      f;
    } sched_outcome_t;

    localparam int SETTLE_CYCLES = 4;
    localparam int SEG_ITEMS     = 240;

    // ------------------------------------------------------------------------
    // Scoreboard: ready-queue predictor plus in-order result check
    // ------------------------------------------------------------------------
    class sched_scoreboard;
        entry_t              slots [QUEUE_DEPTH];
        int unsigned         head_slot;
        int unsigned         tail_slot;
        int unsigned         queued;
        logic [QUANT_W-1:0]  slice_count;
        bit                  held_aside;
        logic [TIME_W-1:0]   clock_now;
        logic [SUM_W-1:0]    wait_total;
        logic [SUM_W-1:0]    resp_total;
        logic [QUANT_W-1:0]  quantum;
        sched_outcome_t      pending_results [$];
        int                  errors;

        function new();
            head_slot   = 0;
            tail_slot   = 0;
            queued      = 0;
            slice_count = '0;
            held_aside  = 1'b0;
            clock_now   = '0;
            wait_total  = '0;
            resp_total  = '0;
            quantum     = QUANTUM_RESET;
            errors      = 0;
        endfunction

        function int unsigned wrap_inc(int unsigned p);
            return (p + 1) % QUEUE_DEPTH;
        endfunction

        // Totals stick at all ones instead of wrapping
        function logic [SUM_W-1:0] add_capped(logic [SUM_W-1:0] acc,
                                              logic [TIME_W-1:0] inc);
            logic [SUM_W-1:0] top;
            top = '1;
            if (acc > top - SUM_W'(inc)) begin
                return top;
            end
            return acc + SUM_W'(inc);
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function int unsigned occupancy();
            return queued;
        endfunction

        // Accepted input transaction: advance the scheduler and queue the result
        function void note_item(logic mode, logic [ID_W-1:0] pid,
                                logic [BURST_W-1:0] burst);
            sched_outcome_t   r;
            entry_t           e;
            logic [TIME_W-1:0] delta;
            r = '0;
            if (mode == MODE_ARRIVE) begin
                if (burst == '0) begin
                    r.status = STAT_ZERO_BURST;
                end else if (queued >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    e.id      = pid;
                    e.arrival = clock_now;
                    e.rem     = burst;
                    e.burst   = burst;
                    e.started = 1'b0;
                    slots[tail_slot] = e;
                    tail_slot = wrap_inc(tail_slot);
                    queued++;
                    r.status = STAT_ACCEPTED;
                end
            end else begin
                // preempted process goes behind the arrivals since the last tick
                if (held_aside) begin
                    slots[tail_slot] = slots[head_slot];
                    head_slot  = wrap_inc(head_slot);
                    tail_slot  = wrap_inc(tail_slot);
                    held_aside = 1'b0;
                end
                if (queued == 0) begin
                    clock_now = clock_now + 1;
                    r.status  = STAT_IDLE;
                end else begin
                    e = slots[head_slot];
                    r.status   = STAT_RAN;
                    r.f.ran_id = e.id;
                    if (!e.started) begin
                        e.started         = 1'b1;
                        delta             = clock_now - e.arrival;
                        r.f.first_run     = 1'b1;
                        r.f.response_time = delta;
                        resp_total        = add_capped(resp_total, delta);
                    end
                    if (e.rem != '0) begin
                        e.rem = e.rem - 1'b1;
                    end
                    if (slice_count != '1) begin
                        slice_count = slice_count + 1'b1;
                    end
                    clock_now = clock_now + 1;
                    if (e.rem == '0) begin
                        delta         = clock_now - e.arrival - TIME_W'(e.burst);
                        r.f.finished  = 1'b1;
                        r.f.wait_time = delta;
                        wait_total    = add_capped(wait_total, delta);
                        head_slot     = wrap_inc(head_slot);
                        queued--;
                        slice_count   = '0;
                    end else begin
                        slots[head_slot] = e;
                        if (quantum != '0 && slice_count >= quantum) begin
                            slice_count = '0;
                            held_aside  = 1'b1;
                        end
                    end
                end
            end
            r.f.total_wait     = wait_total;
            r.f.total_response = resp_total;
            r.f.now            = clock_now;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Accepted result transaction: compare with the oldest prediction
        function void check_result(logic [STAT_W-1:0] status, logic [M_DATA_W-1:0] data);
            sched_outcome_t want;
            sched_fields_t  got;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, status %0d, data %h",
                         $time, status, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            got  = data;
            compare_field("status", 64'(want.status), 64'(status));
            compare_field("ran_id", 64'(want.f.ran_id), 64'(got.ran_id));
            compare_field("first_run", 64'(want.f.first_run), 64'(got.first_run));
            compare_field("response_time", 64'(want.f.response_time),
                          64'(got.response_time));
            compare_field("finished", 64'(want.f.finished), 64'(got.finished));
            compare_field("wait_time", 64'(want.f.wait_time), 64'(got.wait_time));
            compare_field("total_wait", 64'(want.f.total_wait), 64'(got.total_wait));
            compare_field("total_response", 64'(want.f.total_response),
                          64'(got.total_response));
            compare_field("now", 64'(want.f.now), 64'(got.now));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_DATA_W-1:0]    m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   cfg_wr_en;
    logic [QUANT_W-1:0]     cfg_wr_data;

    sched_scoreboard sb = new();
    int src_idle_pct  = 29;
    int sink_idle_pct = 60;
    int items_sent    = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    round_robin_quantum_scheduler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // One input transaction; valid is held high across back-to-back items
    task automatic send_item(input logic mode, input logic [ID_W-1:0] pid,
                             input logic [BURST_W-1:0] burst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {burst, pid};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        sb.note_item(mode, pid, burst);
        items_sent++;
    endtask

    // Stop sending and wait for every predicted result, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_quantum(input logic [QUANT_W-1:0] q);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= q;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.quantum = q;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------------
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tuser, m_axis_tdata);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [QUANT_W-1:0] quanta [6];
        logic [QUANT_W-1:0] q;
        int                 seg_end;
        int                 pick;
        int                 n;

        quanta = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd7, 16'd2};

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_ARRIVE;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= QUANTUM_RESET;
        aresetn       <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle tick, zero burst, first runs, preemption with an
        // arrival while the preempted process is held aside, completions
        send_item(MODE_TICK,   16'h0000, 16'd0);
        send_item(MODE_ARRIVE, 16'h0000, 16'd0);
        send_item(MODE_ARRIVE, 16'hFFFF, 16'd3);
        send_item(MODE_ARRIVE, 16'h0000, 16'd1);
        send_item(MODE_ARRIVE, 16'h5A5A, 16'd2);
        send_item(MODE_TICK,   16'h0000, 16'd0);
        send_item(MODE_TICK,   16'h0000, 16'd0);
        send_item(MODE_ARRIVE, 16'hA5A5, 16'd1);
        repeat (6) send_item(MODE_TICK, 16'hFFFF, 16'hFFFF);
        // longest burst stays in the queue for the rest of the run
        send_item(MODE_ARRIVE, 16'h8001, 16'hFFFF);
        send_item(MODE_ARRIVE, 16'h7FFE, 16'd2);
        repeat (4) send_item(MODE_TICK, 16'h0000, 16'd0);

        // Random segments, one quantum each; idling pattern changes every two
        for (int seg = 0; seg < 6; seg++) begin
            q = (seg == 4) ? QUANT_W'($urandom_range(4, 12)) : quanta[seg];
            write_quantum(q);
            unique case (seg / 2)
                0: begin
                    src_idle_pct  = 29;
                    sink_idle_pct = 60;
                end
                1: begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 29;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            seg_end = items_sent + SEG_ITEMS;
            while (items_sent < seg_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    // workload: mostly short jobs, a rare long one
                    n = $urandom_range(8, 24);
                    repeat (n) begin
                        if ($urandom_range(0, 99) < 25) begin
                            send_item(MODE_ARRIVE, ID_W'($urandom()),
                                      ($urandom_range(0, 127) == 0) ?
                                      BURST_W'($urandom_range(1, 65535)) :
                                      BURST_W'($urandom_range(1, 4)));
                        end else begin
                            send_item(MODE_TICK, ID_W'($urandom()), BURST_W'($urandom()));
                        end
                    end
                end else if (pick < 63) begin
                    // fill to capacity, then overflow: zero burst first, then full
                    while (sb.occupancy() < QUEUE_DEPTH) begin
                        send_item(MODE_ARRIVE, ID_W'($urandom()),
                                  BURST_W'($urandom_range(1, 3)));
                    end
                    send_item(MODE_ARRIVE, ID_W'($urandom()), 16'd0);
                    repeat (2) begin
                        send_item(MODE_ARRIVE, ID_W'($urandom()),
                                  BURST_W'($urandom_range(1, 65535)));
                    end
                end else if (pick < 85) begin
                    // drain
                    n = $urandom_range(10, 40);
                    repeat (n) send_item(MODE_TICK, ID_W'($urandom()), BURST_W'($urandom()));
                end else begin
                    // noise: zero-burst arrivals mixed with ticks
                    n = $urandom_range(2, 6);
                    repeat (n) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_item(MODE_ARRIVE, ID_W'($urandom()), 16'd0);
                        end else begin
                            send_item(MODE_TICK, ID_W'($urandom()), BURST_W'($urandom()));
                        end
                    end
                end
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
